/* hdl/shd_pkg.sv */
package shd_pkg;

    localparam int KIND_W        = 2;
    localparam int NODE_W        = 6;
    localparam int COUNT_W       = 7;
    localparam int DIST_W        = 12;
    localparam int MARK_W        = 2;
    localparam int MAX_NODES_DEF = 64;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;
    localparam logic [DIST_W-1:0]  DIST_MAX       = 12'hFFF;

    // Item kinds on the input channel.
    localparam logic [KIND_W-1:0] KIND_GRAPH_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GRAPH_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH  = 2'd2;

    // Mark bits held per pair.
    localparam logic [MARK_W-1:0] MARK_NONE = 2'b00;
    localparam logic [MARK_W-1:0] MARK_A    = 2'b01;
    localparam logic [MARK_W-1:0] MARK_B    = 2'b10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              bad_edge_seen;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_WALK,
        ST_DRAIN
    } t_sweep_state;

    typedef struct packed {
        logic run;
        logic mem_we;
        logic done;
    } t_sweep_ctl;

endpackage

/* hdl/edge_set_hamming_distance.sv */
// Structural Hamming distance between two undirected edge sets.
//
// Input channel (i_in_valid / o_in_ready, word i_in): each word is an edge
// of graph A, an edge of graph B, or a finish request. Edges are folded to
// (smaller, larger) and marked in a pair memory; endpoints at or above the
// configured node count only raise the bad-edge flag.
// Output channel (o_out_valid / i_out_ready, word o_out): one word per
// finish request, with the count of pairs marked in exactly one graph.
//
// Throughput: one edge word per cycle. The mark memory is read on accept
// and written back in the next cycle; a bypass register covers
// back-to-back edges on the same pair. A finish request walks and clears
// every entry at one address per cycle, then passes a drain state before
// its result is registered; no input is taken during the walk.
// After reset the memory is swept to zero while o_in_ready stays low;
// i_cfg_we is honoured at all times.
// The result waits in an output register: edges are still accepted while
// the receiver stalls, but the next finish request is held off until the
// pending result has been taken.
module edge_set_hamming_distance #(
    parameter int MAX_NODES = shd_pkg::MAX_NODES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  shd_pkg::t_in_word           i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output shd_pkg::t_out_word          o_out,
    input  logic                        i_cfg_we,
    input  logic [shd_pkg::COUNT_W-1:0] i_cfg_data
);

    localparam int DEPTH  = MAX_NODES * MAX_NODES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [shd_pkg::COUNT_W-1:0] r_node_count;
    logic                        r_bad;
    logic                        r_fin_bad;
    logic                        r_s1_valid;
    logic [ADDR_W-1:0]           r_s1_addr;
    logic [shd_pkg::MARK_W-1:0]  r_s1_mask;
    logic                        r_fw_valid;
    logic [ADDR_W-1:0]           r_fw_addr;
    logic [shd_pkg::MARK_W-1:0]  r_fw_data;
    logic                        r_out_valid;
    shd_pkg::t_out_word          r_out;

    shd_pkg::t_sweep_ctl         sweep_ctl;
    logic [ADDR_W-1:0]           sweep_addr;
    logic [shd_pkg::DIST_W-1:0]  sweep_dist;

    logic                        accept;
    logic                        is_edge;
    logic                        is_finish;
    logic                        in_range;
    logic [shd_pkg::NODE_W-1:0]  lo, hi;
    logic [ADDR_W-1:0]           edge_addr;
    logic [shd_pkg::MARK_W-1:0]  old_mark;
    logic [shd_pkg::MARK_W-1:0]  new_mark;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [shd_pkg::MARK_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]           mem_raddr;
    logic [shd_pkg::MARK_W-1:0]  mem_rdata;

    assign is_edge   = (i_in.kind == shd_pkg::KIND_GRAPH_A) ||
                       (i_in.kind == shd_pkg::KIND_GRAPH_B);
    assign is_finish = (i_in.kind == shd_pkg::KIND_FINISH);

    assign o_in_ready = sweep_ctl.run && !(r_out_valid && is_finish);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        in_range = ({1'b0, i_in.node_a} < r_node_count) &&
                   ({1'b0, i_in.node_b} < r_node_count) &&
                   (32'(i_in.node_a) < MAX_NODES) &&
                   (32'(i_in.node_b) < MAX_NODES);
        if (i_in.node_a < i_in.node_b) begin
            lo = i_in.node_a;
            hi = i_in.node_b;
        end else begin
            lo = i_in.node_b;
            hi = i_in.node_a;
        end
        edge_addr = ADDR_W'(ADDR_W'(lo) * ADDR_W'(MAX_NODES)) + ADDR_W'(hi);
    end

    // The write-back of the previous edge lands after this edge's read was
    // issued, so a match on the same pair takes the bypassed value.
    always_comb begin
        if (r_fw_valid && r_fw_addr == r_s1_addr) begin
            old_mark = r_fw_data;
        end else begin
            old_mark = mem_rdata;
        end
        new_mark = old_mark | r_s1_mask;
    end

    always_comb begin
        if (sweep_ctl.mem_we) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr;
            mem_wdata = shd_pkg::MARK_NONE;
        end else begin
            mem_we    = r_s1_valid;
            mem_waddr = r_s1_addr;
            mem_wdata = new_mark;
        end
        mem_raddr = sweep_ctl.run ? edge_addr : sweep_addr;
    end

    shd_mark_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    shd_sweep #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_sweep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && is_finish),
        .i_rdata    (mem_rdata),
        .o_ctl      (sweep_ctl),
        .o_addr     (sweep_addr),
        .o_distance (sweep_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= shd_pkg::NODE_COUNT_RST;
            r_bad        <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_fw_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            if (accept && is_edge && !in_range) begin
                r_bad <= 1'b1;
            end else if (accept && is_finish) begin
                r_bad <= 1'b0;
            end
            r_s1_valid <= accept && is_edge && in_range;
            r_fw_valid <= r_s1_valid;
            if (sweep_ctl.done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= edge_addr;
        r_s1_mask <= (i_in.kind == shd_pkg::KIND_GRAPH_A) ? shd_pkg::MARK_A
                                                           : shd_pkg::MARK_B;
        r_fw_addr <= r_s1_addr;
        r_fw_data <= new_mark;
        if (accept && is_finish) begin
            r_fin_bad <= r_bad;
        end
        if (sweep_ctl.done) begin
            r_out.distance      <= sweep_dist;
            r_out.bad_edge_seen <= r_fin_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* hdl/shd_mark_mem.sv */
module shd_mark_mem #(
    parameter int DEPTH  = shd_pkg::MAX_NODES_DEF * shd_pkg::MAX_NODES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  logic [shd_pkg::MARK_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]         i_raddr,
    output logic [shd_pkg::MARK_W-1:0] o_rdata
);

    logic [shd_pkg::MARK_W-1:0] r_marks [DEPTH];
    logic [shd_pkg::MARK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_marks[i_waddr] <= i_wdata;
        end
    end

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_marks[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/shd_sweep.sv */
module shd_sweep #(
    parameter int DEPTH  = shd_pkg::MAX_NODES_DEF * shd_pkg::MAX_NODES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [shd_pkg::MARK_W-1:0] i_rdata,
    output shd_pkg::t_sweep_ctl        o_ctl,
    output logic [ADDR_W-1:0]          o_addr,
    output logic [shd_pkg::DIST_W-1:0] o_distance
);

    shd_pkg::t_sweep_state      r_state, n_state;
    logic [ADDR_W-1:0]          r_addr;
    logic                       r_rd_valid;
    logic [shd_pkg::DIST_W-1:0] r_dist, n_dist;
    logic                       last;
    logic                       hit;

    assign last = (r_addr == ADDR_W'(DEPTH - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shd_pkg::ST_CLEAR: if (last) n_state = shd_pkg::ST_RUN;
            shd_pkg::ST_RUN:   if (i_start) n_state = shd_pkg::ST_WALK;
            shd_pkg::ST_WALK:  if (last) n_state = shd_pkg::ST_DRAIN;
            shd_pkg::ST_DRAIN: n_state = shd_pkg::ST_RUN;
            default:           n_state = shd_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            shd_pkg::ST_CLEAR: o_ctl.mem_we = 1'b1;
            shd_pkg::ST_RUN:   o_ctl.run = 1'b1;
            shd_pkg::ST_WALK:  o_ctl.mem_we = 1'b1;
            shd_pkg::ST_DRAIN: o_ctl.done = 1'b1;
            default:           o_ctl = '0;
        endcase
    end

    // The data for the final address arrives in the drain cycle, so the
    // result is taken from the combinational count there.
    always_comb begin
        hit = r_rd_valid && (i_rdata == shd_pkg::MARK_A || i_rdata == shd_pkg::MARK_B);
        if (hit && r_dist != shd_pkg::DIST_MAX) begin
            n_dist = r_dist + 1'b1;
        end else begin
            n_dist = r_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= shd_pkg::ST_CLEAR;
            r_addr     <= '0;
            r_rd_valid <= 1'b0;
            r_dist     <= '0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= (r_state == shd_pkg::ST_WALK);
            if (r_state == shd_pkg::ST_CLEAR || r_state == shd_pkg::ST_WALK) begin
                r_addr <= last ? '0 : r_addr + 1'b1;
            end
            if (i_start) begin
                r_dist <= '0;
            end else begin
                r_dist <= n_dist;
            end
        end
    end

    assign o_addr     = r_addr;
    assign o_distance = n_dist;

endmodule

/* hdl/shd_checker.sv */
module shd_checker #(
    parameter int MAX_NODES = shd_pkg::MAX_NODES_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input shd_pkg::t_in_word           i_in,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input shd_pkg::t_out_word          o_out
);

    localparam int PAIRS = MAX_NODES * (MAX_NODES + 1) / 2;
    localparam logic [shd_pkg::DIST_W-1:0] DIST_BOUND =
        (PAIRS > 4095) ? shd_pkg::DIST_MAX : shd_pkg::DIST_W'(PAIRS);

    logic fin_accept;

    assign fin_accept = i_in_valid && o_in_ready && (i_in.kind == shd_pkg::KIND_FINISH);

    // The memory sweep after reset keeps the input closed.
    a_reset_closes_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input open straight after reset");

    // A finish request starts the walk, which holds the input closed.
    a_walk_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_accept |=> !o_in_ready)
        else $error("input open while walking the pair memory");

    // Only unordered pairs are counted, so the distance cannot exceed their number.
    a_distance_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.distance <= DIST_BOUND)
        else $error("distance larger than the number of pairs");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

endmodule

bind edge_set_hamming_distance shd_checker #(.MAX_NODES(MAX_NODES)) u_shd_checker (.*);

/* tb/edge_set_hamming_distance_tb.sv */
`timescale 1ns / 100ps

module edge_set_hamming_distance_tb;

    localparam logic [shd_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int PAIR_CNT    = shd_pkg::MAX_NODES_DEF * shd_pkg::MAX_NODES_DEF;
    localparam int SETTLE_CYC  = 16;
    localparam int IDLE_LIMIT  = 30000;
    localparam int EDGE_TARGET = 850;
    localparam int SUM_TARGET  = 40;

    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    shd_pkg::t_in_word             i_in        = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    shd_pkg::t_out_word            o_out;
    logic                          i_cfg_we    = 1'b0;
    logic [shd_pkg::COUNT_W-1:0]   i_cfg_data  = shd_pkg::NODE_COUNT_RST;

    // Words waiting to be sent, and distances predicted but not yet received.
    shd_pkg::t_in_word             pending_words[$];
    shd_pkg::t_out_word            distance_q[$];

    // Predictor state: two mark bits per pair, the bad-edge flag and node count.
    bit [shd_pkg::MARK_W-1:0]      pair_marks_q[PAIR_CNT];
    bit                            bad_edge_q  = 1'b0;
    logic [shd_pkg::COUNT_W-1:0]   node_limit  = shd_pkg::NODE_COUNT_RST;

    logic                 in_took     = 1'b0;
    int unsigned          send_gap    = 0;
    int unsigned          stall_left  = 0;
    bit                   send_steady = 1'b0;
    bit                   take_steady = 1'b0;
    int unsigned          idle_cycles = 0;
    int unsigned          fail_count  = 0;
    int unsigned          results_seen = 0;
    int unsigned          edges_queued = 0;
    int unsigned          sums_queued  = 0;

    edge_set_hamming_distance DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        $display("%0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [shd_pkg::NODE_W-1:0] rand_node(input int unsigned lo_n,
                                                             input int unsigned hi_n);
        int unsigned v;
        v = $urandom_range(lo_n, hi_n);
        return v[shd_pkg::NODE_W-1:0];
    endfunction

    function automatic logic [shd_pkg::COUNT_W-1:0] rand_count(input int unsigned lo_c,
                                                               input int unsigned hi_c);
        int unsigned v;
        v = $urandom_range(lo_c, hi_c);
        return v[shd_pkg::COUNT_W-1:0];
    endfunction

    // Marks an edge or, on a finish word, counts pairs held by exactly one
    // graph and queues the predicted result.
    task automatic fold_word(input shd_pkg::t_in_word w);
        int unsigned        n_eff;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        pair_diff;
        shd_pkg::t_out_word res;
        case (w.kind)
            shd_pkg::KIND_GRAPH_A, shd_pkg::KIND_GRAPH_B: begin
                n_eff = (node_limit > shd_pkg::MAX_NODES_DEF) ? shd_pkg::MAX_NODES_DEF
                                                              : node_limit;
                if (w.node_a >= n_eff || w.node_b >= n_eff) begin
                    bad_edge_q = 1'b1;
                end else begin
                    lo = (w.node_a < w.node_b) ? w.node_a : w.node_b;
                    hi = (w.node_a < w.node_b) ? w.node_b : w.node_a;
                    pair_marks_q[lo * shd_pkg::MAX_NODES_DEF + hi] |=
                        (w.kind == shd_pkg::KIND_GRAPH_A) ? shd_pkg::MARK_A
                                                          : shd_pkg::MARK_B;
                end
            end
            shd_pkg::KIND_FINISH: begin
                pair_diff = 0;
                foreach (pair_marks_q[i]) begin
                    if ((pair_marks_q[i] == shd_pkg::MARK_A ||
                         pair_marks_q[i] == shd_pkg::MARK_B) &&
                        pair_diff < shd_pkg::DIST_MAX)
                        pair_diff++;
                    pair_marks_q[i] = shd_pkg::MARK_NONE;
                end
                res.distance      = pair_diff[shd_pkg::DIST_W-1:0];
                res.bad_edge_seen = bad_edge_q;
                distance_q.push_back(res);
                bad_edge_q = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic queue_word(input logic [shd_pkg::KIND_W-1:0] k,
                              input logic [shd_pkg::NODE_W-1:0] a,
                              input logic [shd_pkg::NODE_W-1:0] b);
        shd_pkg::t_in_word w;
        w.kind   = k;
        w.node_a = a;
        w.node_b = b;
        pending_words.push_back(w);
        if (k == shd_pkg::KIND_GRAPH_A || k == shd_pkg::KIND_GRAPH_B) edges_queued++;
        if (k == shd_pkg::KIND_FINISH) sums_queued++;
    endtask

    // Returns once every word has gone in, every result has come back and
    // any trailing edge has had time to be written.
    task automatic wait_idle();
        while (pending_words.size() != 0 || i_in_valid || distance_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_node_count(input logic [shd_pkg::COUNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        node_limit = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Driver: presents words and toggles the receiver's ready on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 49) == 0) send_steady = !send_steady;
            if ($urandom_range(0, 49) == 0) take_steady = !take_steady;
            if (!i_in_valid || in_took) begin
                if (send_gap > 0) begin
                    i_in_valid <= 1'b0;
                    send_gap = send_gap - 1;
                end else if (pending_words.size() > 0) begin
                    i_in       <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap = send_steady ? 0 : draw_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                i_out_ready <= 1'b1;
                if (!take_steady && $urandom_range(0, 3) == 0) stall_left = draw_gap();
            end
        end
    end

    // Monitor: predicts on each accepted input word and checks each result word.
    always @(posedge i_clk) begin
        in_took <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (distance_q.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with none predicted",
                                            results_seen));
                end else begin
                    if (o_out.distance !== distance_q[0].distance)
                        flag_mismatch($sformatf("result %0d: distance %0d, predicted %0d",
                                                results_seen, o_out.distance,
                                                distance_q[0].distance));
                    if (o_out.bad_edge_seen !== distance_q[0].bad_edge_seen)
                        flag_mismatch($sformatf("result %0d: bad_edge_seen %b, predicted %b",
                                                results_seen, o_out.bad_edge_seen,
                                                distance_q[0].bad_edge_seen));
                    void'(distance_q.pop_front());
                end
            end
            if (i_in_valid && o_in_ready) fold_word(i_in);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, no word moved for %0d cycles",
                     $realtime, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned n_eff;
        int unsigned lo_w;
        int unsigned hi_w;
        int unsigned r;
        int unsigned edges;
        int unsigned seqs;
        logic [shd_pkg::KIND_W-1:0] k;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset node count: self-loops, extreme nodes, the same pair in both
        // graphs, repeats in either order, and an unused kind.
        queue_word(shd_pkg::KIND_GRAPH_A, 6'd0, 6'd0);
        queue_word(shd_pkg::KIND_GRAPH_A, 6'd63, 6'd63);
        queue_word(shd_pkg::KIND_GRAPH_A, 6'd0, 6'd63);
        queue_word(shd_pkg::KIND_GRAPH_B, 6'd63, 6'd0);
        queue_word(shd_pkg::KIND_GRAPH_A, 6'd5, 6'd9);
        queue_word(shd_pkg::KIND_GRAPH_A, 6'd5, 6'd9);
        queue_word(shd_pkg::KIND_GRAPH_A, 6'd9, 6'd5);
        queue_word(shd_pkg::KIND_GRAPH_B, 6'd10, 6'd20);
        queue_word(shd_pkg::KIND_GRAPH_B, 6'd20, 6'd10);
        queue_word(KIND_UNUSED, 6'd63, 6'd63);
        queue_word(shd_pkg::KIND_FINISH, 6'd0, 6'd0);
        queue_word(shd_pkg::KIND_FINISH, 6'd63, 6'd63);
        wait_idle();

        // A single node: only the self-loop on node 0 is in range.
        set_node_count(7'd1);
        queue_word(shd_pkg::KIND_GRAPH_A, 6'd0, 6'd0);
        queue_word(shd_pkg::KIND_GRAPH_B, 6'd0, 6'd1);
        queue_word(shd_pkg::KIND_FINISH, 6'd0, 6'd0);
        wait_idle();

        // No nodes at all makes every edge out of range.
        set_node_count(7'd0);
        queue_word(shd_pkg::KIND_GRAPH_A, 6'd0, 6'd0);
        queue_word(shd_pkg::KIND_GRAPH_B, 6'd63, 6'd63);
        queue_word(shd_pkg::KIND_FINISH, 6'd0, 6'd0);
        wait_idle();

        // An oversized count saturates; the marks set here must survive the
        // change to a count of two before the finish word.
        set_node_count(7'd127);
        queue_word(shd_pkg::KIND_GRAPH_A, 6'd63, 6'd62);
        queue_word(shd_pkg::KIND_GRAPH_B, 6'd0, 6'd63);
        wait_idle();
        set_node_count(7'd2);
        queue_word(shd_pkg::KIND_GRAPH_A, 6'd1, 6'd0);
        queue_word(shd_pkg::KIND_GRAPH_B, 6'd40, 6'd3);
        queue_word(shd_pkg::KIND_FINISH, 6'd0, 6'd0);

        while (edges_queued + sums_queued < EDGE_TARGET || sums_queued < SUM_TARGET) begin
            wait_idle();
            r = $urandom_range(0, 19);
            if (r == 0)      set_node_count(7'd0);
            else if (r == 1) set_node_count(rand_count(65, 127));
            else if (r < 5)  set_node_count(7'd1);
            else if (r < 10) set_node_count(7'd64);
            else             set_node_count(rand_count(1, 64));
            n_eff = (node_limit > shd_pkg::MAX_NODES_DEF) ? shd_pkg::MAX_NODES_DEF
                                                          : node_limit;
            seqs = $urandom_range(1, 4);
            repeat (seqs) begin
                edges = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(0, 24);
                // A narrow window of nodes makes both graphs hit the same pairs.
                lo_w = 0;
                hi_w = (n_eff > 0) ? n_eff - 1 : 0;
                if (n_eff > 0 && $urandom_range(0, 1) == 0) begin
                    lo_w = $urandom_range(0, n_eff - 1);
                    hi_w = (lo_w + 2 < n_eff) ? lo_w + 2 : n_eff - 1;
                end
                repeat (edges) begin
                    r = $urandom_range(0, 99);
                    k = $urandom_range(0, 1) ? shd_pkg::KIND_GRAPH_B : shd_pkg::KIND_GRAPH_A;
                    if (r < 5)
                        queue_word(KIND_UNUSED, rand_node(0, 63), rand_node(0, 63));
                    else if (r < 13 || n_eff == 0)
                        queue_word(k, rand_node(0, 63), rand_node(0, 63));
                    else
                        queue_word(k, rand_node(lo_w, hi_w), rand_node(lo_w, hi_w));
                end
                // Now and then a sequence is left open across the next count change.
                if ($urandom_range(0, 9) != 0)
                    queue_word(shd_pkg::KIND_FINISH, rand_node(0, 63), rand_node(0, 63));
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
